>>> hw/rtl/assert_macros.svh
// assertion macros shared by the bit packer modules
// expects a clock named clk and a synchronous reset named rst in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/mbp_pkg.sv
// constants and types of the msb-first bit packer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mbp_pkg;

  localparam int CODE_W            = 32;
  localparam int BYTE_W            = 8;
  localparam int CNT_W             = 6;
  localparam int FILL_W            = 3;
  localparam int MAX_BYTES         = 4;
  localparam int JOB_CNT_W         = $clog2(MAX_BYTES + 1);
  localparam int WIN_W             = BYTE_W + CODE_W;
  localparam int DEF_MAX_CODE_BITS = 32;
  localparam int DEF_QUEUE_DEPTH   = 2;

  typedef enum logic {
    OP_PACK  = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // bytes of one request, in output order
  typedef struct packed {
    logic [JOB_CNT_W-1:0]             count;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/mbp_in_if.sv
// code request channel of the bit packer
// depends on mbp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mbp_in_if
  import mbp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [CODE_W-1:0] code;
  logic [CNT_W-1:0]  bit_count;

  modport source (output valid, output operation, output code, output bit_count,
                  input ready);
  modport sink   (input valid, input operation, input code, input bit_count,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mbp_out_if.sv
// byte result channel of the bit packer
// depends on mbp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface mbp_out_if
  import mbp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic              last;

  modport source (output valid, output byte_out, output last, input ready);
  modport sink   (input valid, input byte_out, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mbp_front.sv
// front end: accepts requests, keeps the partial byte, builds byte jobs
// depends on mbp_pkg, mbp_in_if, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mbp_front
  import mbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
  input  wire     clk,
  input  wire     rst,
  mbp_in_if.sink  codes,
  input  q_stat_t q_stat,
  output logic    push,
  output job_t    push_job
);

  localparam int LIMIT = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);
  localparam logic [CNT_W-1:0] WIN_C   = CNT_W'(WIN_W);

  logic [BYTE_W-1:0] partial_byte;
  logic [FILL_W-1:0] bits_filled;
  logic [BYTE_W-1:0] partial_byte_next;
  logic [FILL_W-1:0] bits_filled_next;

  logic              accept;
  logic [CNT_W-1:0]  n;
  logic [CODE_W-1:0] masked;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  sh;
  logic [WIN_W-1:0]  aligned;
  logic [WIN_W-1:0]  win;
  logic [BYTE_W-1:0] win_bytes [MAX_BYTES+1];
  logic [FILL_W-1:0] nbytes;

  assign codes.ready = !q_stat.full;
  assign accept      = codes.valid && codes.ready;

  // saturated count, code cut to its low n bits
  assign n       = (codes.bit_count > LIMIT_C) ? LIMIT_C : codes.bit_count;
  assign masked  = codes.code & ~({CODE_W{1'b1}} << n);
  assign total   = {{(CNT_W-FILL_W){1'b0}}, bits_filled} + n;
  assign sh      = WIN_C - total;
  assign aligned = {{BYTE_W{1'b0}}, masked} << sh;
  assign win     = {partial_byte, {CODE_W{1'b0}}} | aligned;
  assign nbytes  = total[CNT_W-1:FILL_W];

  always_comb begin
    for (int k = 0; k <= MAX_BYTES; k++) begin
      win_bytes[k] = win[WIN_W-1-BYTE_W*k -: BYTE_W];
    end
  end

  always_comb begin
    push              = 1'b0;
    push_job          = '0;
    partial_byte_next = partial_byte;
    bits_filled_next  = bits_filled;
    if (codes.operation == OP_FLUSH) begin
      push_job.count    = JOB_CNT_W'(1);
      push_job.bytes[0] = partial_byte;
      push              = accept && (bits_filled != '0);
      if (accept) begin
        partial_byte_next = '0;
        bits_filled_next  = '0;
      end
    end else begin
      push_job.count = JOB_CNT_W'(nbytes);
      for (int k = 0; k < MAX_BYTES; k++) begin
        push_job.bytes[k] = win_bytes[k];
      end
      push = accept && (nbytes != '0);
      if (accept) begin
        partial_byte_next = win_bytes[nbytes];
        bits_filled_next  = total[FILL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_byte <= '0;
      bits_filled  <= '0;
    end else begin
      partial_byte <= partial_byte_next;
      bits_filled  <= bits_filled_next;
    end
  end

  `MBP_ASSERT_NEXT(a_flush_clears, accept && (codes.operation == OP_FLUSH), bits_filled == '0, "flush left bits behind")
  `MBP_ASSERT(a_push_count, !push || ((push_job.count != '0) && (push_job.count <= JOB_CNT_W'(MAX_BYTES))), "job with bad byte count")

endmodule

`default_nettype wire

>>> hw/rtl/mbp_queue.sv
// short job queue between front and back end
// depends on mbp_pkg, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mbp_queue
  import mbp_pkg::*;
#(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire      clk,
  input  wire      rst,
  input  wire      push,
  input  job_t     push_job,
  input  wire      pop,
  output job_t     head,
  output q_stat_t  q_stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_QW-1:0] DEPTH_C  = CNT_QW'(DEPTH);

  job_t              slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (fill == DEPTH_C);
  assign q_stat.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_QW'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_QW'(1);
      end
    end
  end

  `MBP_ASSERT(a_no_overflow, !(push && q_stat.full), "push into full queue")
  `MBP_ASSERT(a_no_underflow, !(pop && q_stat.empty), "pop from empty queue")

endmodule

`default_nettype wire

>>> hw/rtl/mbp_back.sv
// back end: sends the bytes of the head job one per cycle while the receiver is ready
// depends on mbp_pkg, mbp_out_if, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mbp_back
  import mbp_pkg::*;
(
  input  wire       clk,
  input  wire       rst,
  input  job_t      head,
  input  q_stat_t   q_stat,
  output logic      pop,
  mbp_out_if.source stream
);

  localparam int IDX_W = $clog2(MAX_BYTES);

  logic [IDX_W-1:0] idx;
  logic             at_last;
  logic             take;

  assign at_last = ({{(JOB_CNT_W-IDX_W){1'b0}}, idx} + JOB_CNT_W'(1)) == head.count;
  assign take    = stream.valid && stream.ready;
  assign pop     = take && at_last;

  assign stream.valid    = !q_stat.empty;
  assign stream.byte_out = head.bytes[idx];
  assign stream.last     = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= at_last ? '0 : idx + IDX_W'(1);
    end
  end

  `MBP_ASSERT(a_idx_in_job, !stream.valid || ({{(JOB_CNT_W-IDX_W){1'b0}}, idx} < head.count), "byte index past job")
  `MBP_ASSERT_NEXT(a_idx_restart, pop, idx == '0, "index not reset after job")

endmodule

`default_nettype wire

>>> hw/rtl/msb_first_bit_packer_unit.sv
// top level of the msb-first variable-length bit packer
// depends on mbp_pkg, mbp_in_if, mbp_out_if, mbp_front, mbp_queue, mbp_back
`timescale 1ns / 1ps
`default_nettype none

// Packs codes of 0 to 32 bits, most significant bit first, into a byte stream.
// A pack request places the low bit_count bits of code after the bits already
// held; every byte that fills up goes out on the stream channel with byte_out
// bit 7 holding its first bit, and last marks the final byte of the request.
// A flush request sends the partial byte, zero padded, if it holds any bits.
// bit_count above the limit (32, or MAX_CODE_BITS if smaller) is saturated.
// The front end takes one request per cycle while the job queue has room and
// computes all bytes of a request in that cycle; the back end drains one byte
// per cycle while the receiver is ready. A request yields zero to four bytes;
// the single-byte output port of the back end limits the output rate.

module msb_first_bit_packer_unit
  import mbp_pkg::*;
#(
  parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
  input  wire       clk,
  input  wire       rst,
  mbp_in_if.sink    codes,
  mbp_out_if.source stream
);

  // jobs from front to queue
  logic    push;
  job_t    push_job;
  // head of queue to back end
  logic    pop;
  job_t    head;
  q_stat_t q_stat;

  // bit accumulator and job builder
  mbp_front #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .codes    (codes),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // decouples request intake from byte output
  mbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // byte serializer
  mbp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .stream (stream)
  );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for msb_first_bit_packer_unit
// depends on mbp_pkg, mbp_in_if, mbp_out_if and the packer rtl
// bytes are predicted per accepted request and checked in order on the stream side
`timescale 1ns / 1ps

module testbench;
  import mbp_pkg::*;

  // packer limit used by the predictor, same value handed to the block
  localparam int CODE_LIMIT  = DEF_MAX_CODE_BITS;
  localparam int PACK_LIMIT  = (CODE_LIMIT < CODE_W) ? CODE_LIMIT : CODE_W;
  // long receiver hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 80;
  // settle time after the last byte, generous against the front/queue/back pipe
  localparam int DRAIN_CYCLES = 16;

  // one expected byte on the stream side
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } byte_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic out_ready = 1'b0;

  mbp_in_if  codes_if ();
  mbp_out_if stream_if ();

  assign stream_if.ready = out_ready;

  msb_first_bit_packer_unit #(
    .MAX_CODE_BITS(CODE_LIMIT)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .codes (codes_if),
    .stream(stream_if)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: bits held in the partial byte, left aligned
  logic [BYTE_W-1:0] held_byte = '0;
  int                held_bits = 0;
  byte_result_t      expected_bytes[$];
  int unsigned       mismatch_count = 0;

  // idling controls, changed by the test tasks with nonblocking writes
  logic        source_idle = 1'b0;
  logic        sink_idle   = 1'b0;
  // hold-off handshake between the test tasks and the receiver process
  int unsigned holds_asked  = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;

  // work out the bytes one accepted request causes and queue them
  function automatic void predict_request(op_t op, logic [CODE_W-1:0] code,
                                          logic [CNT_W-1:0] count);
    byte_result_t res;
    int           n;
    int           i;
    int           made;
    made = 0;
    if (op == OP_FLUSH) begin
      // only a partial byte holding bits goes out; code and count don't matter
      if (held_bits != 0) begin
        res.data = held_byte;
        res.last = 1'b1;
        expected_bytes.push_back(res);
      end
      held_byte = '0;
      held_bits = 0;
      return;
    end
    // oversized counts saturate at the limit
    n = (int'(count) > PACK_LIMIT) ? PACK_LIMIT : int'(count);
    for (i = n - 1; i >= 0; i--) begin
      if (code[i])
        held_byte[BYTE_W - 1 - held_bits] = 1'b1;
      held_bits++;
      if (held_bits == BYTE_W) begin
        res.data = held_byte;
        res.last = 1'b0;
        expected_bytes.push_back(res);
        held_byte = '0;
        held_bits = 0;
        made++;
      end
    end
    // last marks the final byte of this request
    if (made != 0)
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
  endfunction

  // offer one request and wait until the block takes it
  task automatic send_request(op_t op, logic [CODE_W-1:0] code, logic [CNT_W-1:0] count);
    int gap;
    if (source_idle && $urandom_range(0, 3) == 0) begin
      // idle burst before this request
      gap = $urandom_range(1, 3);
      codes_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    codes_if.valid     <= 1'b1;
    codes_if.operation <= op;
    codes_if.code      <= code;
    codes_if.bit_count <= count;
    @(posedge clk);
    while (!codes_if.ready)
      @(posedge clk);
    predict_request(op, code, count);
  endtask

  // receiver ready: long hold-offs on request, else random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      hold_left  <= 0;
      stall_left <= 0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 4) == 0) begin
      // stall burst, starting with this cycle
      stall_left <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each byte taken from the stream with the oldest expectation
  byte_result_t head_byte;
  always @(posedge clk) begin
    if (!rst && stream_if.valid && stream_if.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: byte_out %02h last %0b", stream_if.byte_out, stream_if.last);
        mismatch_count++;
      end else begin
        head_byte = expected_bytes.pop_front();
        if (stream_if.byte_out !== head_byte.data) begin
          $error("byte_out: expected %02h actual %02h", head_byte.data, stream_if.byte_out);
          mismatch_count++;
        end
        if (stream_if.last !== head_byte.last) begin
          $error("last: expected %0b actual %0b", head_byte.last, stream_if.last);
          mismatch_count++;
        end
      end
    end
  end

  // corner requests: zero count, extremes, saturation, empty and full flushes
  task automatic test_directed();
    source_idle <= 1'b1;
    sink_idle   <= 1'b1;
    send_request(OP_PACK,  32'hFFFF_FFFF, 6'd0);   // zero count with all code bits set
    send_request(OP_FLUSH, 32'h0000_0000, 6'd0);   // flush with nothing held
    send_request(OP_PACK,  32'h0000_0001, 6'd1);   // single bit, no byte yet
    send_request(OP_PACK,  32'h0000_007F, 6'd7);   // completes exactly one byte
    send_request(OP_PACK,  32'hFFFF_FFFF, 6'd32);  // aligned full word, four bytes
    send_request(OP_PACK,  32'h0000_0000, 6'd32);  // four zero bytes
    send_request(OP_PACK,  32'h0000_0005, 6'd3);   // partial byte
    send_request(OP_PACK,  32'hDEAD_BEEF, 6'd0);   // zero count while bits are held
    send_request(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);  // flush operands ignored
    send_request(OP_FLUSH, 32'hFFFF_FFFF, 6'd63);  // now empty again
    send_request(OP_PACK,  32'hFFFF_FFE0, 6'd5);   // code bits above count dropped
    send_request(OP_PACK,  32'h8000_0001, 6'd32);  // unaligned full word, four bytes
    send_request(OP_PACK,  32'hA5A5_A5A5, 6'd33);  // oversized count saturates
    send_request(OP_PACK,  32'h1234_5678, 6'd63);  // largest count field
    send_request(OP_PACK,  32'h7FFF_FFFF, 6'd31);  // four bytes, four bits left partial at the end
    send_request(OP_PACK,  32'h0000_0001, 6'd1);   // one bit, no byte yet
    send_request(OP_PACK,  32'h0000_00AB, 6'd8);   // unaligned single byte
    send_request(OP_PACK,  32'h0000_0002, 6'd2);
    send_request(OP_FLUSH, 32'h0000_0000, 6'd0);   // flush seven bits, zero padded
    send_request(OP_PACK,  32'h0000_007F, 6'd7);
    send_request(OP_FLUSH, 32'h0000_0000, 6'd0);   // flush seven bits
  endtask

  // random request, mostly packs of any size, some flushes and odd counts
  task automatic send_random_request();
    int                pick;
    logic [CNT_W-1:0] count;
    pick = $urandom_range(0, 99);
    if (pick < 12)
      send_request(OP_FLUSH, $urandom, CNT_W'($urandom));
    else begin
      if (pick < 17)
        count = '0;
      else if (pick < 27)
        count = CNT_W'($urandom_range(PACK_LIMIT + 1, (1 << CNT_W) - 1));
      else if (pick < 45)
        count = CNT_W'($urandom_range(24, 32));
      else
        count = CNT_W'($urandom_range(1, 32));
      send_request(OP_PACK, $urandom, count);
    end
  endtask

  // main random stream with idling on both sides
  task automatic test_random_stream();
    source_idle <= 1'b1;
    sink_idle   <= 1'b1;
    repeat (60) send_random_request();
  endtask

  // receiver holds off while wide codes keep coming, filling the job queue
  task automatic test_input_stall();
    source_idle <= 1'b0;
    sink_idle   <= 1'b0;
    holds_asked <= holds_asked + 1;
    repeat (12) send_request(OP_PACK, $urandom, 6'd32);
    send_request(OP_PACK, $urandom, 6'd13);
    send_request(OP_FLUSH, '0, '0);
  endtask

  // closing stretch at full rate, no idling anywhere
  task automatic test_full_rate();
    source_idle <= 1'b0;
    sink_idle   <= 1'b0;
    repeat (30) send_random_request();
    send_request(OP_FLUSH, '0, '0);
  endtask

  initial begin
    codes_if.valid     <= 1'b0;
    codes_if.operation <= OP_PACK;
    codes_if.code      <= '0;
    codes_if.bit_count <= '0;
    rst                <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_stream();
    test_input_stall();
    test_full_rate();

    codes_if.valid <= 1'b0;
    // let the pipe drain every expected byte, then give it some extra cycles
    while (expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
